@@ sv/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg
// Shared constants for the sphere triangle subdivider: field widths, register
// indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  // Default widths of the vertex index and position fields.
  localparam int INDEX_BITS = 20;
  localparam int POS_BITS   = 24;

  // Fixed widths of the radius register and texture coordinates.
  localparam int RADIUS_BITS = 23;
  localparam int TEX_BITS    = 17;

  // Extra scaling of the squared length before the square root.
  localparam int NORM_SHIFT = 12;

  // Register reset values.
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET      = 23'd65536;
  localparam int                     FIRST_INDEX_RESET = 12;

  // Register indexes on the configuration port.
  localparam logic [0:0] REG_RADIUS      = 1'b0;
  localparam logic [0:0] REG_FIRST_INDEX = 1'b1;

endpackage

`default_nettype wire

@@ sv/sphere_triangle_subdivider_unit.sv @@
// The first two corners of a triangle are always taken and held in the front end.
// The third corner pushes a job and is taken only while a queue slot is free;
// record stalls lengthen a job, and saturated axes or a zero-length midpoint end it sooner.
// Throughput is set by the shared square root and divider: one triangle at a time.
// A two-entry job queue lets the next triangle's corners enter during a job.
// Reset (rst, synchronous, active high) clears control state and loads the registers.
// ----------------------------------------------------------------------------
// sphere_triangle_subdivider_unit
// One icosphere midpoint subdivision step: three corners in, three projected
// midpoint vertices and four triangles out, with an APB register port.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_triangle_subdivider_unit #(
  parameter int INDEX_BITS = sts_pkg::INDEX_BITS,
  parameter int POS_BITS   = sts_pkg::POS_BITS,
  localparam int TB        = sts_pkg::TEX_BITS,
  localparam int RB        = sts_pkg::RADIUS_BITS,
  localparam int IN_W      = ((INDEX_BITS + 3 * POS_BITS + 2 * TB + 7) / 8) * 8,
  localparam int OUT_W     = ((3 * POS_BITS + 2 * TB + 3 * INDEX_BITS + 7) / 8) * 8,
  localparam int JOB_W     = 4 * INDEX_BITS + 9 * POS_BITS + 6 * TB
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // corner_index, corner_x, corner_y, corner_z, corner_u, corner_v
  input  wire logic [IN_W-1:0]   s_tdata,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // new_x, new_y, new_z, new_u, new_v, tri_first, tri_second, tri_third
  output logic [OUT_W-1:0]       m_tdata,
  // record_type
  output logic [0:0]             m_tuser,
  output logic                   m_tlast,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int I = INDEX_BITS;
  localparam int P = POS_BITS;

  logic [RB-1:0] sphere_radius;
  logic [I-1:0]  first_new_index;
  logic          cfg_write;
  logic          index_load;

  // Register file.
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign index_load = cfg_write && (paddr[2] == sts_pkg::REG_FIRST_INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius   <= sts_pkg::RADIUS_RESET;
      first_new_index <= I'(sts_pkg::FIRST_INDEX_RESET);
    end else if (cfg_write) begin
      case (paddr[2])
        sts_pkg::REG_RADIUS:      sphere_radius   <= pwdata[RB-1:0];
        sts_pkg::REG_FIRST_INDEX: first_new_index <= pwdata[I-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sts_pkg::REG_RADIUS:      prdata = 32'(sphere_radius);
      sts_pkg::REG_FIRST_INDEX: prdata = 32'(first_new_index);
      default:                  prdata = '0;
    endcase
  end

  // Front end: corner collection.
  logic             queue_full, queue_valid, job_push, job_pop;
  logic [JOB_W-1:0] job_in, job_head;

  sts_front #(.INDEX_BITS(I), .POS_BITS(P)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .corner_index (s_tdata[0 +: I]),
    .corner_x     (s_tdata[I +: P]),
    .corner_y     (s_tdata[I + P +: P]),
    .corner_z     (s_tdata[I + 2 * P +: P]),
    .corner_u     (s_tdata[I + 3 * P +: TB]),
    .corner_v     (s_tdata[I + 3 * P + TB +: TB]),
    .index_load   (index_load),
    .index_value  (pwdata[I-1:0]),
    .queue_full   (queue_full),
    .job_push     (job_push),
    .job_data     (job_in)
  );

  // Job queue.
  sts_queue #(.WIDTH(JOB_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .wdata     (job_in),
    .pop       (job_pop),
    .full      (queue_full),
    .not_empty (queue_valid),
    .rdata     (job_head)
  );

  // Back end: projection and record emission.
  logic [P-1:0]  new_x, new_y, new_z;
  logic [TB-1:0] new_u, new_v;
  logic [I-1:0]  tri_first, tri_second, tri_third;

  sts_back #(.INDEX_BITS(I), .POS_BITS(P)) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (queue_valid),
    .job_data     (job_head),
    .job_pop      (job_pop),
    .radius       (sphere_radius),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .record_type  (m_tuser[0]),
    .new_x        (new_x),
    .new_y        (new_y),
    .new_z        (new_z),
    .new_u        (new_u),
    .new_v        (new_v),
    .tri_first    (tri_first),
    .tri_second   (tri_second),
    .tri_third    (tri_third),
    .final_of_run (m_tlast)
  );

  assign m_tdata = OUT_W'({tri_third, tri_second, tri_first, new_v, new_u,
                           new_z, new_y, new_x});

endmodule

`default_nettype wire

@@ sv/sts_front.sv @@
// ----------------------------------------------------------------------------
// sts_front
// Accepts triangle corners, holds the first two, and on the third corner
// pushes the whole triangle with its base vertex index into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_front #(
  parameter int INDEX_BITS = sts_pkg::INDEX_BITS,
  parameter int POS_BITS   = sts_pkg::POS_BITS,
  localparam int TB        = sts_pkg::TEX_BITS,
  localparam int JOB_W     = 4 * INDEX_BITS + 9 * POS_BITS + 6 * TB
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [INDEX_BITS-1:0]        corner_index,
  input  wire logic signed [POS_BITS-1:0]   corner_x,
  input  wire logic signed [POS_BITS-1:0]   corner_y,
  input  wire logic signed [POS_BITS-1:0]   corner_z,
  input  wire logic [TB-1:0]                corner_u,
  input  wire logic [TB-1:0]                corner_v,
  input  wire logic                         index_load,
  input  wire logic [INDEX_BITS-1:0]        index_value,
  input  wire logic                         queue_full,
  output logic                              job_push,
  output logic [JOB_W-1:0]                  job_data
);

  logic [1:0]            corner_count;
  logic [INDEX_BITS-1:0] next_index;
  logic [INDEX_BITS-1:0] hidx [2];
  logic [POS_BITS-1:0]   hx   [2];
  logic [POS_BITS-1:0]   hy   [2];
  logic [POS_BITS-1:0]   hz   [2];
  logic [TB-1:0]         hu   [2];
  logic [TB-1:0]         hv   [2];
  logic                  accept;
  logic                  third;

  // The third corner needs a free queue slot; the first two are always taken.
  assign third    = (corner_count == 2'd2);
  assign in_ready = !third || !queue_full;
  assign accept   = in_valid && in_ready;
  assign job_push = accept && third;

  // Triangle job, lowest bits first: indexes A, B, C, base, positions, texture.
  assign job_data = {corner_v, corner_u, hv[1], hu[1], hv[0], hu[0],
                     corner_z, corner_y, corner_x,
                     hz[1], hy[1], hx[1], hz[0], hy[0], hx[0],
                     next_index, corner_index, hidx[1], hidx[0]};

  // Corner counter and the running vertex index.
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= 2'd0;
      next_index   <= INDEX_BITS'(sts_pkg::FIRST_INDEX_RESET);
    end else begin
      if (accept) begin
        corner_count <= third ? 2'd0 : corner_count + 2'd1;
      end
      if (index_load) begin
        next_index <= index_value;
      end else if (job_push) begin
        next_index <= next_index + INDEX_BITS'(3);
      end
    end
  end

  // Held corners A and B.
  always_ff @(posedge clk) begin
    if (accept && !third) begin
      hidx[corner_count[0]] <= corner_index;
      hx[corner_count[0]]   <= corner_x;
      hy[corner_count[0]]   <= corner_y;
      hz[corner_count[0]]   <= corner_z;
      hu[corner_count[0]]   <= corner_u;
      hv[corner_count[0]]   <= corner_v;
    end
  end

endmodule

`default_nettype wire

@@ sv/sts_queue.sv @@
// ----------------------------------------------------------------------------
// sts_queue
// Two-entry job queue between the corner front end and the arithmetic back
// end. The head entry stays in place until the back end pops it.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] slot [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign rdata     = slot[rptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ sv/sts_back.sv @@
// ----------------------------------------------------------------------------
// sts_back
// Works one triangle job: per edge it forms the doubled midpoint, its squared
// length, an iterative square root, an iterative division per coordinate
// unless it saturates or the length is zero, and the vertex record; at the
// end, the four triangle records. One output register feeds the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_back #(
  parameter int INDEX_BITS = sts_pkg::INDEX_BITS,
  parameter int POS_BITS   = sts_pkg::POS_BITS,
  localparam int TB        = sts_pkg::TEX_BITS,
  localparam int RB        = sts_pkg::RADIUS_BITS,
  localparam int JOB_W     = 4 * INDEX_BITS + 9 * POS_BITS + 6 * TB
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       job_valid,
  input  wire logic [JOB_W-1:0]           job_data,
  output logic                            job_pop,
  input  wire logic [RB-1:0]              radius,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic                            record_type,
  output logic [POS_BITS-1:0]             new_x,
  output logic [POS_BITS-1:0]             new_y,
  output logic [POS_BITS-1:0]             new_z,
  output logic [TB-1:0]                   new_u,
  output logic [TB-1:0]                   new_v,
  output logic [INDEX_BITS-1:0]           tri_first,
  output logic [INDEX_BITS-1:0]           tri_second,
  output logic [INDEX_BITS-1:0]           tri_third,
  output logic                            final_of_run
);

  localparam int P       = POS_BITS;
  localparam int I       = INDEX_BITS;
  localparam int MB      = P + 1;
  localparam int NB      = 2 * P + 2;
  localparam int XB      = NB + sts_pkg::NORM_SHIFT;
  localparam int R       = XB / 2;
  localparam int PW      = RB + MB;
  localparam int DW      = PW + 7 + P;
  localparam int CB      = $clog2(R + 1);
  localparam int OFF_POS = 4 * I;
  localparam int OFF_TEX = 4 * I + 9 * P;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_EDGE = 10'b0000000010,
    S_SQ   = 10'b0000000100,
    S_SQRT = 10'b0000001000,
    S_MUL  = 10'b0000010000,
    S_SAT  = 10'b0000100000,
    S_DIV  = 10'b0001000000,
    S_VTX  = 10'b0010000000,
    S_TRI  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t        state;
  logic [1:0]    edge_sel;
  logic [1:0]    coord;
  logic [1:0]    tcnt;
  logic [MB-1:0] smag [3];
  logic          sneg [3];
  logic [NB-1:0] nacc;
  logic [XB-1:0] xr;
  logic [R+1:0]  srem;
  logic [R-1:0]  root;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsh;
  logic [P-2:0]  quo;
  logic [CB-1:0] cnt;
  logic [P-1:0]  res [3];

  // Job fields.
  logic [P-1:0]  jp [3][3];
  logic [TB-1:0] jt [3][2];
  logic [I-1:0]  idx_a, idx_b, idx_c, base, n1, n2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 3; c++) begin
        jp[k][c] = job_data[OFF_POS + (k * 3 + c) * P +: P];
      end
      for (int t = 0; t < 2; t++) begin
        jt[k][t] = job_data[OFF_TEX + (k * 2 + t) * TB +: TB];
      end
    end
  end

  assign idx_a = job_data[0 +: I];
  assign idx_b = job_data[I +: I];
  assign idx_c = job_data[2 * I +: I];
  assign base  = job_data[3 * I +: I];
  assign n1    = base + I'(1);
  assign n2    = base + I'(2);

  // Edge endpoints: AB, AC, BC.
  logic [1:0] ea, eb;
  assign ea = (edge_sel == 2'd2) ? 2'd1 : 2'd0;
  assign eb = (edge_sel == 2'd0) ? 2'd1 : 2'd2;

  // Doubled midpoint and its magnitude per coordinate.
  logic signed [MB-1:0] ssum [3];
  logic [MB-1:0]        smag_w [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ssum[c]   = $signed({jp[ea][c][P-1], jp[ea][c]}) + $signed({jp[eb][c][P-1], jp[eb][c]});
      smag_w[c] = ssum[c][MB-1] ? MB'(-ssum[c]) : MB'(ssum[c]);
    end
  end

  // Averaged texture coordinates of the current edge.
  logic [TB:0] usum, vsum;
  assign usum = {1'b0, jt[ea][0]} + {1'b0, jt[eb][0]};
  assign vsum = {1'b0, jt[ea][1]} + {1'b0, jt[eb][1]};

  // Squared length accumulation.
  logic [NB-1:0] sq, nsum;
  assign sq   = smag[coord] * smag[coord];
  assign nsum = nacc + sq;

  // One square root step: two bits of the operand per cycle.
  logic [R+1:0] rem2, trial;
  logic         sq_ge;
  assign rem2  = {srem[R-1:0], xr[XB-1 -: 2]};
  assign trial = {root, 2'b01};
  assign sq_ge = (rem2 >= trial);

  // Scaled numerator: radius * magnitude * 64 + L / 2.
  logic [PW-1:0] prod;
  assign prod = radius * smag[coord];

  // Saturation bound and one division step.
  logic [DW-1:0] sat_bound;
  logic          dv_ge;
  logic [P-2:0]  quo_n;
  assign sat_bound = DW'(root) << (P - 1);
  assign dv_ge     = (rem >= dsh);
  assign quo_n     = {quo[P-3:0], dv_ge};

  // Signed result from a magnitude.
  function automatic logic [P-1:0] with_sign(input logic [P-2:0] m, input logic neg);
    logic [P-1:0] v;
    v = {1'b0, m};
    return neg ? -v : v;
  endfunction

  logic out_free, out_load;
  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && ((state == S_VTX) || (state == S_TRI));
  assign job_pop  = (state == S_DONE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      edge_sel <= 2'd0;
      coord    <= 2'd0;
      tcnt     <= 2'd0;
      cnt      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            edge_sel <= 2'd0;
            state    <= S_EDGE;
          end
        end
        S_EDGE: begin
          coord <= 2'd0;
          state <= S_SQ;
        end
        S_SQ: begin
          if (coord == 2'd2) begin
            cnt   <= CB'(R);
            state <= S_SQRT;
          end else begin
            coord <= coord + 2'd1;
          end
        end
        S_SQRT: begin
          cnt <= cnt - CB'(1);
          if (cnt == CB'(1)) begin
            coord <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (root != '0) begin
            state <= S_SAT;
          end else if (coord == 2'd2) begin
            state <= S_VTX;
          end else begin
            coord <= coord + 2'd1;
          end
        end
        S_SAT: begin
          if (rem >= sat_bound) begin
            if (coord == 2'd2) begin
              state <= S_VTX;
            end else begin
              coord <= coord + 2'd1;
              state <= S_MUL;
            end
          end else begin
            cnt   <= CB'(P - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          cnt <= cnt - CB'(1);
          if (cnt == CB'(1)) begin
            if (coord == 2'd2) begin
              state <= S_VTX;
            end else begin
              coord <= coord + 2'd1;
              state <= S_MUL;
            end
          end
        end
        S_VTX: begin
          if (out_free) begin
            if (edge_sel == 2'd2) begin
              tcnt  <= 2'd0;
              state <= S_TRI;
            end else begin
              edge_sel <= edge_sel + 2'd1;
              state    <= S_EDGE;
            end
          end
        end
        S_TRI: begin
          if (out_free) begin
            tcnt <= tcnt + 2'd1;
            if (tcnt == 2'd3) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Arithmetic datapath.
  always_ff @(posedge clk) begin
    case (state)
      S_EDGE: begin
        for (int c = 0; c < 3; c++) begin
          smag[c] <= smag_w[c];
          sneg[c] <= ssum[c][MB-1];
        end
        nacc <= '0;
      end
      S_SQ: begin
        nacc <= nsum;
        if (coord == 2'd2) begin
          xr   <= {nsum, sts_pkg::NORM_SHIFT'(0)};
          srem <= '0;
          root <= '0;
        end
      end
      S_SQRT: begin
        xr <= xr << 2;
        if (sq_ge) begin
          srem <= rem2 - trial;
          root <= {root[R-2:0], 1'b1};
        end else begin
          srem <= rem2;
          root <= {root[R-2:0], 1'b0};
        end
      end
      S_MUL: begin
        if (root == '0) begin
          res[coord] <= '0;
        end else begin
          rem <= DW'({prod, 6'b0}) + DW'(root >> 1);
        end
      end
      S_SAT: begin
        if (rem >= sat_bound) begin
          res[coord] <= with_sign({(P - 1){1'b1}}, sneg[coord]);
        end else begin
          dsh <= DW'(root) << (P - 2);
          quo <= '0;
        end
      end
      S_DIV: begin
        if (dv_ge) begin
          rem <= rem - dsh;
        end
        dsh <= dsh >> 1;
        quo <= quo_n;
        if (cnt == CB'(1)) begin
          res[coord] <= with_sign(quo_n, sneg[coord]);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_VTX) begin
        record_type  <= 1'b0;
        new_x        <= res[0];
        new_y        <= res[1];
        new_z        <= res[2];
        new_u        <= usum[TB:1];
        new_v        <= vsum[TB:1];
        tri_first    <= '0;
        tri_second   <= '0;
        tri_third    <= '0;
        final_of_run <= 1'b0;
      end else begin
        record_type  <= 1'b1;
        new_x        <= '0;
        new_y        <= '0;
        new_z        <= '0;
        new_u        <= '0;
        new_v        <= '0;
        final_of_run <= (tcnt == 2'd3);
        case (tcnt)
          2'd0: begin
            tri_first <= idx_a; tri_second <= base; tri_third <= n1;
          end
          2'd1: begin
            tri_first <= idx_b; tri_second <= base; tri_third <= n2;
          end
          2'd2: begin
            tri_first <= base;  tri_second <= n1;   tri_third <= n2;
          end
          default: begin
            tri_first <= idx_c; tri_second <= n1;   tri_third <= n2;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire
